/* rtl/intel_hex_record_decoder_top_defines.svh */
// Assertion macros shared by the Intel HEX record decoder checker.
`ifndef INTEL_HEX_RECORD_DECODER_TOP_DEFINES_SVH
`define INTEL_HEX_RECORD_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IHEX_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("intel hex decoder check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IHEX_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("intel hex decoder check failed");

`endif

/* rtl/ihex_pkg.sv */
// Shared types, constants and decode functions for the Intel HEX record decoder.
`timescale 1ns / 1ps

package ihex_pkg;

   // Characters past this position on a line are dropped.
   localparam int unsigned LINE_MAX = 50;
   localparam int unsigned POS_W    = 6;

   // Character codes the decoder reacts to.
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_FOUR    = 8'h34;
   localparam logic [7:0] CHAR_FIVE    = 8'h35;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   // Flash base addresses picked by the top two offset nibbles.
   localparam logic [31:0] BASE_LOW_LOW   = 32'h0800_0000;
   localparam logic [31:0] BASE_LOW_HIGH  = 32'h0800_0800;
   localparam logic [31:0] BASE_HIGH_LOW  = 32'h0800_C000;
   localparam logic [31:0] BASE_HIGH_HIGH = 32'h0800_C800;

   // Record kinds taken from the type field.
   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_IGNORE = 2'd1,
      KIND_EXT    = 2'd2
   } kind_type;

   // One result word: a halfword write, or nothing.
   typedef struct packed {
      logic        write_valid;
      logic [31:0] write_address;
      logic [15:0] write_data;
   } result_type;

   // Hex digit value of an ASCII character; anything else decodes to zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            diff = c - CHAR_UPPER_A + 8'd10;
         end
         hex_value = diff[3:0];
      end
   endfunction

   // Flash base chosen by offset nibbles three and two.
   function automatic logic [31:0] base_for_offset(input logic [15:0] off);
      logic hi_sel;
      logic lo_sel;
      begin
         hi_sel = (off[15:12] >= 4'hC);
         lo_sel = off[11];
         if (hi_sel) begin
            base_for_offset = lo_sel ? BASE_HIGH_HIGH : BASE_HIGH_LOW;
         end else begin
            base_for_offset = lo_sel ? BASE_LOW_HIGH : BASE_LOW_LOW;
         end
      end
   endfunction

endpackage

/* rtl/ihex_parse.sv */
// Line parser: record state registers and the halfword write decode.
`timescale 1ns / 1ps

module ihex_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             rx_char,
   output ihex_pkg::result_type   result
);

   logic [ihex_pkg::POS_W-1:0] char_position_ff, char_position_in;
   logic [7:0]                 record_length_ff, record_length_in;
   logic                       type_high_is_zero_ff, type_high_is_zero_in;
   ihex_pkg::kind_type         record_kind_ff, record_kind_in;
   logic [15:0]                record_offset_ff, record_offset_in;
   logic [11:0]                nibble_hold_ff, nibble_hold_in;
   logic [15:0]                upper_address_ff, upper_address_in;

   logic [3:0]                 digit;
   logic [ihex_pkg::POS_W-1:0] pos;
   logic [ihex_pkg::POS_W-1:0] word_pos;
   logic [3:0]                 word_index;
   logic                       in_line;

   assign pos        = char_position_ff;
   assign digit      = ihex_pkg::hex_value(rx_char);
   assign in_line    = (pos < ihex_pkg::POS_W'(ihex_pkg::LINE_MAX));
   // Halfword index: the group that ends at position 12 + 4i.
   assign word_pos   = pos - ihex_pkg::POS_W'(12);
   assign word_index = word_pos[5:2];

   // Next state and result for the current character.
   always_comb begin
      char_position_in     = char_position_ff;
      record_length_in     = record_length_ff;
      type_high_is_zero_in = type_high_is_zero_ff;
      record_kind_in       = record_kind_ff;
      record_offset_in     = record_offset_ff;
      nibble_hold_in       = nibble_hold_ff;
      upper_address_in     = upper_address_ff;
      result               = '0;

      if (rx_char == ihex_pkg::CHAR_COLON) begin
         char_position_in = ihex_pkg::POS_W'(1);
      end else if (rx_char == ihex_pkg::CHAR_NEWLINE) begin
         char_position_in = '0;
      end else if (in_line) begin
         char_position_in = pos + ihex_pkg::POS_W'(1);
         case (pos)
            6'd0: begin
            end
            6'd1: record_length_in[7:4] = digit;
            6'd2: record_length_in[3:0] = digit;
            6'd3: record_offset_in[15:12] = digit;
            6'd4: record_offset_in[11:8]  = digit;
            6'd5: record_offset_in[7:4]   = digit;
            6'd6: record_offset_in[3:0]   = digit;
            6'd7: type_high_is_zero_in = (rx_char == ihex_pkg::CHAR_ZERO);
            6'd8: begin
               if (type_high_is_zero_ff && (rx_char == ihex_pkg::CHAR_ONE ||
                                            rx_char == ihex_pkg::CHAR_FIVE)) begin
                  record_kind_in = ihex_pkg::KIND_IGNORE;
               end else if (type_high_is_zero_ff && rx_char == ihex_pkg::CHAR_FOUR) begin
                  record_kind_in = ihex_pkg::KIND_EXT;
               end else begin
                  record_kind_in = ihex_pkg::KIND_DATA;
               end
            end
            default: begin
               // Data area: every fourth digit completes a group.
               if (pos[1:0] == 2'b00) begin
                  if (record_kind_ff == ihex_pkg::KIND_EXT && pos == 6'd12) begin
                     upper_address_in = {nibble_hold_ff, digit};
                  end else if (record_kind_ff == ihex_pkg::KIND_DATA &&
                               {3'b000, word_index} < record_length_ff[7:1]) begin
                     result.write_valid   = 1'b1;
                     result.write_address =
                        (ihex_pkg::base_for_offset(record_offset_ff) |
                         {upper_address_ff, record_offset_ff}) +
                        {27'd0, word_index, 1'b0};
                     result.write_data    = {nibble_hold_ff[3:0], digit,
                                             nibble_hold_ff[11:8], nibble_hold_ff[7:4]};
                  end
               end
               nibble_hold_in = {nibble_hold_ff[7:0], digit};
            end
         endcase
      end
   end

   // Record state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff     <= '0;
         record_length_ff     <= '0;
         type_high_is_zero_ff <= 1'b0;
         record_kind_ff       <= ihex_pkg::KIND_DATA;
         record_offset_ff     <= '0;
         nibble_hold_ff       <= '0;
         upper_address_ff     <= '0;
      end else if (take) begin
         char_position_ff     <= char_position_in;
         record_length_ff     <= record_length_in;
         type_high_is_zero_ff <= type_high_is_zero_in;
         record_kind_ff       <= record_kind_in;
         record_offset_ff     <= record_offset_in;
         nibble_hold_ff       <= nibble_hold_in;
         upper_address_ff     <= upper_address_in;
      end
   end

endmodule

/* rtl/ihex_out_reg.sv */
// Result register that holds one word until the consumer takes it.
`timescale 1ns / 1ps

module ihex_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ihex_pkg::result_type load_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 can_load,
   output ihex_pkg::result_type rsp_data
);

   logic                 valid_ff, valid_in;
   ihex_pkg::result_type data_ff;

   // A new word may enter when the register is empty or being drained.
   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

/* rtl/intel_hex_record_decoder_top.sv */
// Top level of the Intel HEX record decoder.
`timescale 1ns / 1ps

// Intel HEX record decoder. Takes the hex text one character per word on the
// req_ channel and returns exactly one result word per character on the rsp_
// channel. A result carries a halfword flash write when that character was the
// fourth digit of a data halfword; otherwise write_valid, address and data are
// zero. One character is accepted every clock cycle while req_ready is high;
// the result is held in the single result register, which also lets a new
// character enter in the cycle a waiting result is taken.
module intel_hex_record_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_valid,
   output logic [31:0] rsp_write_address,
   output logic [15:0] rsp_write_data
);

   logic                 take;
   logic                 can_load;
   ihex_pkg::result_type next_result;
   ihex_pkg::result_type held_result;

   assign req_ready = can_load;
   assign take      = req_valid && can_load;

   // Record parser and its state.
   ihex_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_char (req_rx_char),
      .result  (next_result)
   );

   // Result register.
   ihex_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .load_data (next_result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .rsp_data  (held_result)
   );

   assign rsp_write_valid   = held_result.write_valid;
   assign rsp_write_address = held_result.write_address;
   assign rsp_write_data    = held_result.write_data;

endmodule

/* rtl/ihex_checker.sv */
// Port-level checks for the Intel HEX record decoder, bound to the top level.
`timescale 1ns / 1ps
`include "intel_hex_record_decoder_top_defines.svh"

module ihex_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_write_valid,
   input logic [31:0] rsp_write_address,
   input logic [15:0] rsp_write_data
);

   // A word without a write carries a zero address and zero data.
   `IHEX_ASSERT_NOW(a_idle_word_zero, rsp_valid && !rsp_write_valid, rsp_write_address == 32'd0 && rsp_write_data == 16'd0)

   // An empty result register never holds back the input.
   `IHEX_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready)

   // Every accepted character shows a result in the next cycle.
   `IHEX_ASSERT_NEXT(a_result_follows, req_valid && req_ready, rsp_valid)

   // A stalled result holds its payload.
   `IHEX_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_write_valid) && $stable(rsp_write_address) && $stable(rsp_write_data))

endmodule

bind intel_hex_record_decoder_top ihex_checker u_ihex_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_write_valid   (rsp_write_valid),
   .rsp_write_address (rsp_write_address),
   .rsp_write_data    (rsp_write_data)
);
